FILE: sv/csf_pkg.sv
`timescale 1ns / 1ps

package csf_pkg;

  localparam int COORD_BITS = 24;
  localparam int ANGLE_BITS = 16;
  localparam int RAD_BITS   = 16;
  localparam int GAP_BITS   = 8;
  localparam int GUARD_BITS = 16;
  localparam int DP_W       = COORD_BITS + 20;
  localparam int OFS_W      = DP_W - GUARD_BITS;
  localparam int SUM_W      = OFS_W + 1;
  localparam int Z_W        = 34;
  localparam int ATAN_W     = 30;
  localparam int STEP_W     = 5;
  localparam int DIST_W     = RAD_BITS + 2;
  localparam int KINV_W     = 30;
  localparam int PROD_W     = DIST_W + KINV_W;

  localparam logic [KINV_W-1:0] KINV_Q30 = KINV_W'(652032874);
  localparam logic [GAP_BITS-1:0] GAP_RESET = GAP_BITS'(3);

  typedef struct packed {
    logic                         is_head;
    logic                         last_segment;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic [RAD_BITS-1:0]          seg_radius;
  } seg_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] new_x;
    logic signed [COORD_BITS-1:0] new_y;
    logic signed [ANGLE_BITS-1:0] heading;
    logic                         moved;
    logic                         chain_end;
  } place_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_VEC,
    ST_RINIT,
    ST_ROT,
    ST_ROUND,
    ST_PLACE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              take;
    logic              pre_en;
    logic              vec_en;
    logic              rinit_en;
    logic              rot_en;
    logic              round_en;
    logic              place_en;
    logic              out_valid;
    logic [STEP_W-1:0] step;
  } ctrl_t;

  // Arctangent of 2^-i with pi equal to 2^31.
  function automatic logic [ATAN_W-1:0] atan_q31(input logic [STEP_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = ATAN_W'(536870912);
      5'd1:    v = ATAN_W'(316933406);
      5'd2:    v = ATAN_W'(167458907);
      5'd3:    v = ATAN_W'(85004756);
      5'd4:    v = ATAN_W'(42667331);
      5'd5:    v = ATAN_W'(21354465);
      5'd6:    v = ATAN_W'(10679838);
      5'd7:    v = ATAN_W'(5340245);
      5'd8:    v = ATAN_W'(2670163);
      5'd9:    v = ATAN_W'(1335087);
      5'd10:   v = ATAN_W'(667544);
      5'd11:   v = ATAN_W'(333772);
      5'd12:   v = ATAN_W'(166886);
      5'd13:   v = ATAN_W'(83443);
      5'd14:   v = ATAN_W'(41722);
      5'd15:   v = ATAN_W'(20861);
      5'd16:   v = ATAN_W'(10430);
      5'd17:   v = ATAN_W'(5215);
      5'd18:   v = ATAN_W'(2608);
      5'd19:   v = ATAN_W'(1304);
      5'd20:   v = ATAN_W'(652);
      5'd21:   v = ATAN_W'(326);
      5'd22:   v = ATAN_W'(163);
      5'd23:   v = ATAN_W'(81);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/chain_segment_follow.sv
`timescale 1ns / 1ps
// A head segment is echoed independent of CORDIC_STEPS: its result is valid in the cycle after transfer.
// A following segment passes through the states PRE, VEC, RINIT, ROT, ROUND and PLACE before its result
// is valid in OUT; one shared CORDIC stage is used for vectoring, then rotation.
// One segment is in flight at a time; the next transfer is taken the cycle after a result leaves.
// Synchronous active-high reset clears the anchor to zero and sets gap to 3.

module chain_segment_follow #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         seg_valid,
  output logic                         seg_stall,
  input  csf_pkg::seg_t                seg,
  output logic                         place_valid,
  input  logic                         place_stall,
  output csf_pkg::place_t              place,
  input  logic                         gap_valid,
  output logic                         gap_ready,
  input  logic [csf_pkg::GAP_BITS-1:0] gap_data
);
  import csf_pkg::*;

  localparam int CNT_W = $clog2(CORDIC_STEPS);
  localparam logic signed [DP_W-1:0] HALF  = DP_W'(1) <<< (GUARD_BITS - 1);
  localparam logic signed [DP_W-1:0] HALF1 = HALF + DP_W'(1);
  localparam logic signed [DP_W-1:0] UNIT_X = DP_W'(1) <<< GUARD_BITS;
  localparam logic signed [Z_W-1:0] QUARTER = Z_W'(1) <<< 30;
  localparam logic signed [Z_W-1:0] Z_RND = Z_W'(1) <<< (31 - ANGLE_BITS);
  localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) <<< (COORD_BITS - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);
  localparam logic [PROD_W-1:0] PROD_RND = PROD_W'(1) << 13;

  ctrl_t ctrl;
  logic  seg_fire;
  logic  place_fire;

  logic [GAP_BITS-1:0]          gap;
  logic signed [COORD_BITS-1:0] anchor_x;
  logic signed [COORD_BITS-1:0] anchor_y;
  logic [RAD_BITS-1:0]          anchor_radius;

  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic [RAD_BITS-1:0]          rad;
  logic                         last;

  logic signed [DP_W-1:0]   x;
  logic signed [DP_W-1:0]   y;
  logic signed [Z_W-1:0]    z;
  logic                     pre_pos;
  logic                     pre_neg;
  logic [CORDIC_STEPS-1:0]  cw;
  logic [DIST_W-1:0]        reach;
  logic [PROD_W-1:0]        prod;
  logic signed [OFS_W-1:0]  ox;
  logic signed [OFS_W-1:0]  oy;

  logic signed [DP_W-1:0]  dxp;
  logic signed [DP_W-1:0]  dxn;
  logic signed [DP_W-1:0]  dyp;
  logic signed [DP_W-1:0]  dyn;
  logic signed [DP_W-1:0]  xn;
  logic signed [DP_W-1:0]  yn;
  logic                    sigma_pos;
  logic signed [ATAN_W:0]  atan_s;
  logic signed [DP_W-1:0]  tx;
  logic signed [DP_W-1:0]  ty;
  logic signed [SUM_W-1:0] sx;
  logic signed [SUM_W-1:0] sy;
  logic signed [SUM_W-1:0] cx;
  logic signed [SUM_W-1:0] cy;
  logic signed [Z_W-1:0]   zr;

  assign seg_fire   = seg_valid && !seg_stall;
  assign place_fire = place_valid && !place_stall;
  assign seg_stall  = !ctrl.take;
  assign place_valid = ctrl.out_valid;
  assign gap_ready  = 1'b1;

  csf_seq #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .seg_fire  (seg_fire),
    .seg_head  (seg.is_head),
    .place_fire(place_fire),
    .ctrl      (ctrl)
  );

  // Offsets from the anchor, both signs, already scaled by the guard bits.
  assign dxp = (DP_W'(pos_x) - DP_W'(anchor_x)) <<< GUARD_BITS;
  assign dxn = (DP_W'(anchor_x) - DP_W'(pos_x)) <<< GUARD_BITS;
  assign dyp = (DP_W'(pos_y) - DP_W'(anchor_y)) <<< GUARD_BITS;
  assign dyn = (DP_W'(anchor_y) - DP_W'(pos_y)) <<< GUARD_BITS;

  // Vectoring drives y toward zero; rotation replays the recorded decisions in the same order, each direction reversed.
  assign sigma_pos = ctrl.rot_en ? cw[ctrl.step[CNT_W-1:0]] : y[DP_W-1];

  csf_cordic_step u_step (
    .x        (x),
    .y        (y),
    .sh       (ctrl.step),
    .sigma_pos(sigma_pos),
    .xn       (xn),
    .yn       (yn)
  );

  assign atan_s = $signed({1'b0, atan_q31(ctrl.step)});

  // Undo the prerotation while adding the rounding half; a negation uses ~v + 1.
  always_comb begin
    if (pre_pos) begin
      tx = ~y + HALF1;
      ty = x + HALF;
    end else if (pre_neg) begin
      tx = y + HALF;
      ty = ~x + HALF1;
    end else begin
      tx = x + HALF;
      ty = y + HALF;
    end
  end

  assign sx = SUM_W'(anchor_x) + SUM_W'(ox);
  assign sy = SUM_W'(anchor_y) + SUM_W'(oy);
  assign cx = (sx > SAT_HI) ? SAT_HI : ((sx < SAT_LO) ? SAT_LO : sx);
  assign cy = (sy > SAT_HI) ? SAT_HI : ((sy < SAT_LO) ? SAT_LO : sy);
  assign zr = z + Z_RND;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap           <= GAP_RESET;
      anchor_x      <= '0;
      anchor_y      <= '0;
      anchor_radius <= '0;
    end else begin
      if (gap_valid && gap_ready) begin
        gap <= gap_data;
      end
      if (seg_fire && seg.is_head) begin
        anchor_x      <= seg.pos_x;
        anchor_y      <= seg.pos_y;
        anchor_radius <= seg.seg_radius;
      end else if (ctrl.place_en) begin
        anchor_x      <= COORD_BITS'(cx);
        anchor_y      <= COORD_BITS'(cy);
        anchor_radius <= rad;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (seg_fire) begin
      pos_x <= seg.pos_x;
      pos_y <= seg.pos_y;
      rad   <= seg.seg_radius;
      last  <= seg.last_segment;
      if (seg.is_head) begin
        place.new_x     <= seg.pos_x;
        place.new_y     <= seg.pos_y;
        place.heading   <= '0;
        place.moved     <= 1'b0;
        place.chain_end <= seg.last_segment;
      end
    end
    if (ctrl.pre_en) begin
      reach   <= DIST_W'(anchor_radius) + DIST_W'(rad) + DIST_W'(gap);
      pre_pos <= 1'b0;
      pre_neg <= 1'b0;
      if ((pos_x == anchor_x) && (pos_y == anchor_y)) begin
        x <= UNIT_X;
        y <= '0;
        z <= '0;
      end else if ((pos_x < anchor_x) && !(pos_y < anchor_y)) begin
        x       <= dyp;
        y       <= dxn;
        z       <= QUARTER;
        pre_pos <= 1'b1;
      end else if (pos_x < anchor_x) begin
        x       <= dyn;
        y       <= dxp;
        z       <= -QUARTER;
        pre_neg <= 1'b1;
      end else begin
        x <= dxp;
        y <= dyp;
        z <= '0;
      end
    end
    if (ctrl.vec_en) begin
      x    <= xn;
      y    <= yn;
      z    <= y[DP_W-1] ? (z - Z_W'(atan_s)) : (z + Z_W'(atan_s));
      cw[ctrl.step[CNT_W-1:0]] <= !y[DP_W-1];
      prod <= PROD_W'(reach) * PROD_W'(KINV_Q30);
    end
    if (ctrl.rinit_en) begin
      x <= DP_W'((prod + PROD_RND) >> 14);
      y <= '0;
    end
    if (ctrl.rot_en) begin
      x <= xn;
      y <= yn;
    end
    if (ctrl.round_en) begin
      ox <= tx[DP_W-1:GUARD_BITS];
      oy <= ty[DP_W-1:GUARD_BITS];
    end
    if (ctrl.place_en) begin
      place.new_x     <= COORD_BITS'(cx);
      place.new_y     <= COORD_BITS'(cy);
      place.heading   <= zr[31:32-ANGLE_BITS];
      place.moved     <= 1'b1;
      place.chain_end <= last;
    end
  end

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    seg_fire |=> seg_stall)
    else $error("segment transfer did not make the block busy");

  a_no_take_while_result: assert property (@(posedge clk) disable iff (rst)
    place_valid |-> seg_stall)
    else $error("segment taken while a result waits");

  a_head_echo: assert property (@(posedge clk) disable iff (rst)
    seg_fire && seg.is_head |=> place_valid && !place.moved && (place.heading == '0))
    else $error("head segment was not echoed in the next cycle");

  a_moved_after_walk: assert property (@(posedge clk) disable iff (rst)
    seg_fire && !seg.is_head |=> !place_valid)
    else $error("placed segment result appeared too early");

endmodule

FILE: sv/csf_cordic_step.sv
`timescale 1ns / 1ps

module csf_cordic_step (
  input  logic signed [csf_pkg::DP_W-1:0]   x,
  input  logic signed [csf_pkg::DP_W-1:0]   y,
  input  logic        [csf_pkg::STEP_W-1:0] sh,
  input  logic                              sigma_pos,
  output logic signed [csf_pkg::DP_W-1:0]   xn,
  output logic signed [csf_pkg::DP_W-1:0]   yn
);
  import csf_pkg::*;

  logic signed [DP_W-1:0] xs;
  logic signed [DP_W-1:0] ys;

  assign xs = x >>> sh;
  assign ys = y >>> sh;
  assign xn = sigma_pos ? (x - ys) : (x + ys);
  assign yn = sigma_pos ? (y + xs) : (y - xs);

endmodule

FILE: sv/csf_seq.sv
`timescale 1ns / 1ps

module csf_seq #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           seg_fire,
  input  logic           seg_head,
  input  logic           place_fire,
  output csf_pkg::ctrl_t ctrl
);
  import csf_pkg::*;

  localparam int CNT_W = $clog2(CORDIC_STEPS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CORDIC_STEPS - 1);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = '0;
    case (state)
      ST_IDLE: begin
        if (seg_fire) begin
          state_next = seg_head ? ST_OUT : ST_PRE;
        end
      end
      ST_PRE: begin
        state_next = ST_VEC;
      end
      ST_VEC: begin
        if (cnt == LAST_STEP) begin
          state_next = ST_RINIT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_RINIT: begin
        state_next = ST_ROT;
      end
      ST_ROT: begin
        if (cnt == LAST_STEP) begin
          state_next = ST_ROUND;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_ROUND: begin
        state_next = ST_PLACE;
      end
      ST_PLACE: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (place_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl      = '0;
    ctrl.step = STEP_W'(cnt);
    case (state)
      ST_IDLE:  ctrl.take      = 1'b1;
      ST_PRE:   ctrl.pre_en    = 1'b1;
      ST_VEC:   ctrl.vec_en    = 1'b1;
      ST_RINIT: ctrl.rinit_en  = 1'b1;
      ST_ROT:   ctrl.rot_en    = 1'b1;
      ST_ROUND: ctrl.round_en  = 1'b1;
      ST_PLACE: ctrl.place_en  = 1'b1;
      ST_OUT:   ctrl.out_valid = 1'b1;
      default:  ctrl.take      = 1'b0;
    endcase
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import csf_pkg::*;

  localparam int STEPS = 16;
  localparam longint COORD_MAX = 64'sd8388607;
  localparam longint COORD_MIN = -64'sd8388608;
  localparam longint HALF_PI = 64'sd1073741824;
  localparam longint KINV = 64'sd652032874;
  localparam longint CYCLE_LIMIT = 1000000;
  localparam longint ATAN_TAB [STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_RUNS,
    STALL_HEAVY
  } stall_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic seg_valid = 1'b0;
  logic seg_stall;
  seg_t seg = '0;
  logic place_valid;
  logic place_stall = 1'b0;
  place_t place;
  logic gap_valid = 1'b0;
  logic gap_ready;
  logic [GAP_BITS-1:0] gap_data = '0;

  longint anchor_x;
  longint anchor_y;
  longint anchor_radius;
  logic [GAP_BITS-1:0] gap_setting;

  place_t pending_places[$];
  place_t want_place;
  int errors = 0;
  int items_sent = 0;
  longint cycles = 0;

  stall_mode_t stall_mode = STALL_NONE;
  int hold_left = 0;
  int stall_run = 0;
  logic stall_level = 1'b0;
  bit pace_on = 1'b0;
  int burst_left = 0;

  chain_segment_follow #(.CORDIC_STEPS(STEPS)) dut (
    .clk(clk),
    .rst(rst),
    .seg_valid(seg_valid),
    .seg_stall(seg_stall),
    .seg(seg),
    .place_valid(place_valid),
    .place_stall(place_stall),
    .place(place),
    .gap_valid(gap_valid),
    .gap_ready(gap_ready),
    .gap_data(gap_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint sat_coord(input longint v);
    return v > COORD_MAX ? COORD_MAX : (v < COORD_MIN ? COORD_MIN : v);
  endfunction

  function automatic place_t place_segment(input seg_t s);
    place_t r;
    longint px, py, dx, dy, x, y, z, xs, ys, t, reach, rx, ry, ox, oy, nx, ny, hd;
    int pre;
    int i;
    bit cw [STEPS];
    px = longint'(s.pos_x);
    py = longint'(s.pos_y);
    r.chain_end = s.last_segment;
    if (s.is_head) begin
      anchor_x = px;
      anchor_y = py;
      anchor_radius = longint'(s.seg_radius);
      r.new_x = s.pos_x;
      r.new_y = s.pos_y;
      r.heading = '0;
      r.moved = 1'b0;
      return r;
    end
    dx = px - anchor_x;
    dy = py - anchor_y;
    if (dx == 0 && dy == 0) dx = 1;
    x = dx * 65536;
    y = dy * 65536;
    z = 0;
    pre = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = HALF_PI;
        pre = 1;
      end else begin
        x = -y;
        y = t;
        z = -HALF_PI;
        pre = -1;
      end
    end
    for (i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      cw[i] = (y >= 0);
      if (cw[i]) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_TAB[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_TAB[i];
      end
    end
    reach = anchor_radius + longint'(s.seg_radius) + longint'(gap_setting);
    rx = (reach * KINV + 64'sd8192) >>> 14;
    ry = 0;
    for (i = 0; i < STEPS; i++) begin
      xs = rx >>> i;
      ys = ry >>> i;
      if (cw[i]) begin
        rx = rx - ys;
        ry = ry + xs;
      end else begin
        rx = rx + ys;
        ry = ry - xs;
      end
    end
    if (pre == 1) begin
      t = rx;
      rx = -ry;
      ry = t;
    end else if (pre == -1) begin
      t = rx;
      rx = ry;
      ry = -t;
    end
    ox = (rx + 64'sd32768) >>> 16;
    oy = (ry + 64'sd32768) >>> 16;
    nx = sat_coord(anchor_x + ox);
    ny = sat_coord(anchor_y + oy);
    hd = (z + 64'sd32768) >>> 16;
    anchor_x = nx;
    anchor_y = ny;
    anchor_radius = longint'(s.seg_radius);
    r.new_x = nx[COORD_BITS-1:0];
    r.new_y = ny[COORD_BITS-1:0];
    r.heading = hd[ANGLE_BITS-1:0];
    r.moved = 1'b1;
    return r;
  endfunction

  function automatic longint pick_coord(input longint anchor);
    logic signed [COORD_BITS-1:0] raw;
    int span;
    longint ofs;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        span = $urandom_range(0, 20);
        ofs = longint'($urandom_range(0, 2 * (1 << span))) - longint'(1 << span);
        return sat_coord(anchor + ofs);
      end
      6, 7: begin
        raw = COORD_BITS'($urandom());
        return longint'(raw);
      end
      8: begin
        case ($urandom_range(0, 3))
          0: return COORD_MAX;
          1: return COORD_MIN;
          2: return 0;
          default: return anchor;
        endcase
      end
      default: return anchor;
    endcase
  endfunction

  function automatic seg_t make_segment(input bit head, input bit last);
    seg_t s;
    longint px, py;
    px = pick_coord(anchor_x);
    py = pick_coord(anchor_y);
    s.is_head = head;
    s.last_segment = last;
    s.pos_x = px[COORD_BITS-1:0];
    s.pos_y = py[COORD_BITS-1:0];
    case ($urandom_range(0, 7))
      5: s.seg_radius = RAD_BITS'($urandom_range(0, 65535));
      6: s.seg_radius = '0;
      7: s.seg_radius = '1;
      default: s.seg_radius = RAD_BITS'($urandom_range(0, 1023));
    endcase
    return s;
  endfunction

  task automatic report_error(input string msg);
    errors++;
    if (errors <= 100) $display("ERROR at cycle %0d: %s", cycles, msg);
  endtask

  task automatic send_segment(input seg_t s);
    seg <= s;
    seg_valid <= 1'b1;
    @(posedge clk);
    while (seg_stall) @(posedge clk);
    pending_places.push_back(place_segment(s));
    items_sent++;
  endtask

  task automatic pace_sender();
    if (!pace_on) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      seg_valid <= 1'b0;
      repeat ($urandom_range(1, 45)) @(posedge clk);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  task automatic send_offset(input longint dx, input longint dy, input int rad,
                             input bit last);
    seg_t s;
    longint px, py;
    px = sat_coord(anchor_x + dx);
    py = sat_coord(anchor_y + dy);
    s.is_head = 1'b0;
    s.last_segment = last;
    s.pos_x = px[COORD_BITS-1:0];
    s.pos_y = py[COORD_BITS-1:0];
    s.seg_radius = rad[RAD_BITS-1:0];
    send_segment(s);
  endtask

  task automatic send_head(input longint px, input longint py, input int rad,
                           input bit last);
    seg_t s;
    s.is_head = 1'b1;
    s.last_segment = last;
    s.pos_x = px[COORD_BITS-1:0];
    s.pos_y = py[COORD_BITS-1:0];
    s.seg_radius = rad[RAD_BITS-1:0];
    send_segment(s);
  endtask

  task automatic drain_places();
    seg_valid <= 1'b0;
    @(posedge clk);
    while (pending_places.size() != 0) @(posedge clk);
  endtask

  // Only called once the block is idle, with no segment on offer.
  task automatic write_gap(input logic [GAP_BITS-1:0] value);
    gap_data <= value;
    gap_valid <= 1'b1;
    @(posedge clk);
    while (!gap_ready) @(posedge clk);
    gap_setting = value;
    gap_valid <= 1'b0;
  endtask

  task automatic send_chain(input int len);
    int k;
    send_segment(make_segment(1'b1, len == 0));
    pace_sender();
    for (k = 1; k <= len; k++) begin
      send_segment(make_segment(1'b0, k == len));
      pace_sender();
    end
  endtask

  task automatic test_orphan_after_reset();
    send_offset(1000, -500, 100, 1'b0);
    send_offset(-20000, 7000, 0, 1'b1);
  endtask

  task automatic test_directed_cases();
    send_head(0, 0, 256, 1'b0);
    send_offset(0, 0, 128, 1'b0);
    send_offset(5000, 0, 64, 1'b0);
    send_offset(0, 5000, 64, 1'b0);
    send_offset(-5000, 3000, 64, 1'b0);
    send_offset(-5000, -3000, 64, 1'b0);
    send_offset(-4000, 0, 64, 1'b0);
    send_offset(0, -4000, 64, 1'b0);
    send_offset(3, -7, 0, 1'b1);
    send_head(COORD_MAX - 10, COORD_MAX - 10, 65535, 1'b0);
    send_offset(10, 10, 65535, 1'b0);
    send_offset(0, 0, 65535, 1'b1);
    send_head(COORD_MIN + 10, COORD_MIN + 10, 65535, 1'b0);
    send_offset(-10, -10, 65535, 1'b1);
    send_head(COORD_MIN, COORD_MAX, 0, 1'b1);
    send_offset(COORD_MAX - COORD_MIN, COORD_MIN - COORD_MAX, 0, 1'b1);
    send_head(COORD_MAX, COORD_MIN, 65535, 1'b1);
    send_offset(COORD_MIN - COORD_MAX, 0, 65535, 1'b0);
  endtask

  task automatic test_gap_settings();
    logic [GAP_BITS-1:0] values [4];
    int k;
    values = '{8'd0, 8'd255, 8'd1, 8'd128};
    for (k = 0; k < 4; k++) begin
      drain_places();
      write_gap(values[k]);
      send_chain(3);
    end
  endtask

  task automatic test_backpressure();
    drain_places();
    pace_on = 1'b0;
    hold_left = 400;
    send_chain(5);
    drain_places();
    stall_mode = STALL_RUNS;
    send_chain(6);
    drain_places();
  endtask

  task automatic test_random_chains();
    int start_count;
    int phase;
    start_count = items_sent;
    phase = 0;
    while (items_sent - start_count < 1200) begin
      if ((items_sent - start_count) / 150 != phase) begin
        phase = (items_sent - start_count) / 150;
        drain_places();
        case ($urandom_range(0, 3))
          0: write_gap('0);
          1: write_gap('1);
          default: write_gap(GAP_BITS'($urandom_range(0, 255)));
        endcase
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        pace_on = $urandom_range(0, 3) != 0;
        burst_left = 0;
      end
      case ($urandom_range(0, 9))
        8: begin
          send_segment(make_segment(1'b0, 1'($urandom_range(0, 1))));
          pace_sender();
        end
        9: begin
          send_segment(make_segment(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
          pace_sender();
        end
        default: send_chain($urandom_range(1, 10));
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      place_stall <= 1'b0;
    end else if (hold_left > 0) begin
      place_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      case (stall_mode)
        STALL_NONE: place_stall <= 1'b0;
        STALL_LIGHT: place_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: place_stall <= ($urandom_range(0, 3) != 0);
        default: begin
          if (stall_run == 0) begin
            stall_level = ~stall_level;
            stall_run = $urandom_range(1, 50);
          end else begin
            stall_run = stall_run - 1;
          end
          place_stall <= stall_level;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && place_valid && !place_stall) begin
      if (pending_places.size() == 0) begin
        report_error($sformatf("unexpected result x=%0d y=%0d heading=%0d",
                               place.new_x, place.new_y, place.heading));
      end else begin
        want_place = pending_places.pop_front();
        if (place.new_x !== want_place.new_x)
          report_error($sformatf("new_x got %0d expected %0d", place.new_x, want_place.new_x));
        if (place.new_y !== want_place.new_y)
          report_error($sformatf("new_y got %0d expected %0d", place.new_y, want_place.new_y));
        if (place.heading !== want_place.heading)
          report_error($sformatf("heading got %0d expected %0d", place.heading,
                                 want_place.heading));
        if (place.moved !== want_place.moved)
          report_error($sformatf("moved got %0b expected %0b", place.moved, want_place.moved));
        if (place.chain_end !== want_place.chain_end)
          report_error($sformatf("chain_end got %0b expected %0b", place.chain_end,
                                 want_place.chain_end));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    gap_setting = GAP_RESET;
    anchor_x = 0;
    anchor_y = 0;
    anchor_radius = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_orphan_after_reset();
    test_directed_cases();
    stall_mode = STALL_LIGHT;
    test_gap_settings();
    test_backpressure();
    test_random_chains();
    drain_places();
    repeat (2 * STEPS + 25) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
